/* hw/rtl/cata_pkg.sv */
package cata_pkg;

  localparam int unsigned SLOTS     = 8;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned PRICE_W   = 32;
  localparam int unsigned WHO_W     = 4;
  localparam int unsigned ROUND_W   = 5;
  localparam int unsigned BANKS     = 3;
  localparam int unsigned RAM_DEPTH = BANKS * SLOTS * SLOTS;
  localparam int unsigned RAM_AW    = 8;

  localparam logic [WHO_W-1:0] NONE_WHO = 4'hF;

  typedef enum logic [1:0] {
    OP_PRICE = 2'd0,
    OP_BID   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_FORM  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_BID     = 2'd0,
    KIND_ASSIGN  = 2'd1,
    KIND_INVALID = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_OWN_VEHICLE = 2'd0,
    REG_TASK_COUNT  = 2'd1,
    REG_ADJACENCY   = 2'd2,
    REG_ITER_LIMIT  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [WHO_W-1:0]   who;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    entry_t            data;
  } ram_wr_t;

endpackage

/* hw/rtl/cata_bank_ram.sv */
module cata_bank_ram import cata_pkg::*; (
  input  logic              clk_i,
  input  ram_wr_t           wr_i,
  input  logic [RAM_AW-1:0] rd_addr_i,
  output entry_t            rd_data_o
);

  entry_t mem [RAM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

/* hw/rtl/consensus_auction_task_assigner.sv */
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+---------------------------------------------
// command   | in        | start & !busy         | op, task_req, price, who, sender, iteration, last
// result    | out       | result_valid_o        | kind, auction_number, bid_round, task_index,
//           |           |                       | bid_price, winner, final_res
// config    | in        | psel&penable&pwrite   | paddr (8 bytes per register), pwdata, prdata
//
// plain entries, flush and new formation keep the block idle; busy stays low
// a last price entry runs the task select walk over the n lanes, then emits n results
// a last bid entry files the staged table into the bank ram (start bank, then main bank),
// then runs consensus over every lane and vehicle through the single ram read port,
// then a rebid walk over the n lanes when outbid, and then the results
// reset is asynchronous active low; the receiver cannot stall results
module consensus_auction_task_assigner import cata_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op_i,
  input  logic [2:0]                task_req_i,
  input  logic [PRICE_W-1:0]        price_i,
  input  logic signed [WHO_W-1:0]   who_i,
  input  logic [2:0]                sender_i,
  input  logic [ROUND_W-1:0]        iteration_i,
  input  logic                      last_i,
  output logic                      result_valid_o,
  output logic [1:0]                kind_o,
  output logic [15:0]               auction_number_o,
  output logic [ROUND_W-1:0]        bid_round_o,
  output logic [2:0]                task_index_o,
  output logic [PRICE_W-1:0]        bid_price_o,
  output logic signed [WHO_W-1:0]   winner_o,
  output logic                      final_res_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FILE, ST_CHECK, ST_CONS_RD, ST_CONS_CMP,
    ST_SELECT, ST_ADVANCE, ST_FINISH, ST_EMIT
  } state_e;

  state_e state_q;

  logic [2:0]  own_vehicle_q;
  logic [3:0]  task_count_q;
  logic [63:0] adjacency_q;
  logic [4:0]  iter_limit_q;

  logic [PRICE_W-1:0] own_price_q [SLOTS];
  entry_t             stage_q [SLOTS];
  entry_t             tbl_q [SLOTS];
  logic [2:0]         perm_q [SLOTS];

  logic [SLOTS-1:0] mark_cur_q, mark_nxt_q, mark_start_q;
  logic [1:0]       cur_bank_q, nxt_bank_q, start_bank_q;
  logic [4:0]       bid_iter_q;
  logic [15:0]      auction_q;
  logic             open_q, fnew_q;

  logic [2:0] sender_q, sweep_q;
  logic       file_start_q, file_main_q;
  logic [1:0] main_bank_q;

  logic [2:0] j_q, v_q;
  entry_t     best_q;
  logic       have_q, outbid_q;

  logic [PRICE_W-1:0] sel_best_q;
  logic [2:0]         sel_task_q;
  logic               sel_found_q, sel_cons_q;

  kind_e      emit_kind_q;
  logic [4:0] emit_round_q;
  logic       clear_after_q;

  logic               out_valid_q, out_final_q;
  kind_e              out_kind_q;
  logic [15:0]        out_auction_q;
  logic [4:0]         out_round_q;
  logic [2:0]         out_task_q;
  logic [PRICE_W-1:0] out_price_q;
  logic [WHO_W-1:0]   out_who_q;

  logic       accept, cfg_wr;
  logic [3:0] n_lanes;
  logic [2:0] last_lane;
  logic [3:0] me_who;
  logic       complete, valid_perm, same_perm;
  logic [2:0] pos;

  ram_wr_t ram_wr;
  logic [RAM_AW-1:0] ram_rd_addr;
  entry_t ram_rd_data;

  // filing decisions for a last bid entry
  logic       fs, fc_eq, fn_eq, fmain;

  // consensus step
  entry_t cand, best_nx;
  logic   cand_ok, cand_take, outbid_nx;

  // task select step
  logic [PRICE_W-1:0] sel_p;
  logic               sel_take;

  logic [5:0] iter_nx;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (reg_e'(paddr[4:3]))
      REG_OWN_VEHICLE: prdata = 64'(own_vehicle_q);
      REG_TASK_COUNT:  prdata = 64'(task_count_q);
      REG_ADJACENCY:   prdata = adjacency_q;
      REG_ITER_LIMIT:  prdata = 64'(iter_limit_q);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    if (task_count_q == 4'd0) begin
      n_lanes = 4'd1;
    end else if (task_count_q > 4'(SLOTS)) begin
      n_lanes = 4'(SLOTS);
    end else begin
      n_lanes = task_count_q;
    end
  end

  assign last_lane = 3'(n_lanes - 4'd1);
  assign me_who    = {1'b0, own_vehicle_q};

  // formation point of this agent, then every neighbour must have a current table
  always_comb begin
    pos      = '0;
    complete = 1'b1;
    for (int j = 0; j < SLOTS; j++) begin
      if (perm_q[j] == own_vehicle_q) pos = 3'(j);
    end
    for (int j = 0; j < SLOTS; j++) begin
      if (4'(j) < n_lanes && adjacency_q[{pos, 3'(j)}] && !mark_cur_q[perm_q[j]]) begin
        complete = 1'b0;
      end
    end
  end

  always_comb begin
    valid_perm = 1'b1;
    same_perm  = 1'b1;
    for (int j = 0; j < SLOTS; j++) begin
      if (4'(j) < n_lanes) begin
        if (tbl_q[j].who >= n_lanes) valid_perm = 1'b0;
        for (int k = 0; k < j; k++) begin
          if (tbl_q[k].who == tbl_q[j].who) valid_perm = 1'b0;
        end
        if ({1'b0, perm_q[j]} != tbl_q[j].who) same_perm = 1'b0;
      end
    end
  end

  always_comb begin
    fs    = (iteration_i == 5'd0) && !mark_start_q[sender_i];
    fc_eq = (iteration_i == bid_iter_q);
    fn_eq = !fc_eq && ({1'b0, iteration_i} == 6'(bid_iter_q) + 6'd1);
    fmain = open_q && ((fc_eq && !mark_cur_q[sender_i]) ||
                       (fn_eq && !mark_nxt_q[sender_i]));
  end

  always_comb begin
    cand_ok = 1'b1;
    if (mark_cur_q[v_q]) begin
      cand = ram_rd_data;
    end else begin
      cand    = tbl_q[j_q];
      cand_ok = (v_q == own_vehicle_q);
    end
    cand_take = cand_ok && (!have_q || cand.price > best_q.price);
    best_nx   = cand_take ? cand : best_q;
    outbid_nx = outbid_q || (tbl_q[j_q].who == me_who && best_nx.who != me_who);
  end

  assign sel_p    = own_price_q[j_q];
  assign sel_take = (sel_p > sel_best_q) && (sel_p > tbl_q[j_q].price);
  assign iter_nx  = 6'(bid_iter_q) + 6'd1;

  always_comb begin
    ram_wr.en   = (state_q == ST_FILE);
    ram_wr.addr = {(file_start_q ? start_bank_q : main_bank_q), sender_q, sweep_q};
    ram_wr.data = stage_q[sweep_q];
  end

  assign ram_rd_addr = {cur_bank_q, v_q, j_q};

  cata_bank_ram u_bank_ram (
    .clk_i,
    .wr_i      (ram_wr),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // staged payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept && op_e'(op_i) == OP_PRICE) begin
      own_price_q[task_req_i] <= price_i;
    end
    if (accept && op_e'(op_i) == OP_BID) begin
      stage_q[task_req_i] <= {price_i, who_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      own_vehicle_q <= '0;
      task_count_q  <= 4'd8;
      adjacency_q   <= '0;
      iter_limit_q  <= 5'd16;
      for (int j = 0; j < SLOTS; j++) begin
        tbl_q[j]  <= {{PRICE_W{1'b0}}, NONE_WHO};
        perm_q[j] <= 3'(j);
      end
      mark_cur_q    <= '0;
      mark_nxt_q    <= '0;
      mark_start_q  <= '0;
      cur_bank_q    <= 2'd0;
      nxt_bank_q    <= 2'd1;
      start_bank_q  <= 2'd2;
      bid_iter_q    <= '0;
      auction_q     <= '1;
      open_q        <= 1'b0;
      fnew_q        <= 1'b0;
      sender_q      <= '0;
      sweep_q       <= '0;
      file_start_q  <= 1'b0;
      file_main_q   <= 1'b0;
      main_bank_q   <= '0;
      j_q           <= '0;
      v_q           <= '0;
      best_q        <= '0;
      have_q        <= 1'b0;
      outbid_q      <= 1'b0;
      sel_best_q    <= '0;
      sel_task_q    <= '0;
      sel_found_q   <= 1'b0;
      sel_cons_q    <= 1'b0;
      emit_kind_q   <= KIND_BID;
      emit_round_q  <= '0;
      clear_after_q <= 1'b0;
      out_valid_q   <= 1'b0;
      out_final_q   <= 1'b0;
      out_kind_q    <= KIND_BID;
      out_auction_q <= '0;
      out_round_q   <= '0;
      out_task_q    <= '0;
      out_price_q   <= '0;
      out_who_q     <= '0;
    end else begin
      out_valid_q <= (state_q == ST_EMIT) || (state_q == ST_FINISH && !valid_perm);

      if (cfg_wr) begin
        case (reg_e'(paddr[4:3]))
          REG_OWN_VEHICLE: own_vehicle_q <= pwdata[2:0];
          REG_TASK_COUNT:  task_count_q  <= pwdata[3:0];
          REG_ADJACENCY:   adjacency_q   <= pwdata;
          REG_ITER_LIMIT:  iter_limit_q  <= pwdata[4:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (op_e'(op_i))
              OP_PRICE: begin
                if (last_i) begin
                  bid_iter_q <= '0;
                  for (int j = 0; j < SLOTS; j++) tbl_q[j] <= {{PRICE_W{1'b0}}, NONE_WHO};
                  // the start bank becomes the current bank
                  mark_cur_q   <= mark_start_q;
                  mark_nxt_q   <= '0;
                  mark_start_q <= '0;
                  cur_bank_q   <= start_bank_q;
                  start_bank_q <= cur_bank_q;
                  open_q       <= 1'b1;
                  auction_q    <= auction_q + 16'd1;
                  j_q          <= '0;
                  sel_best_q   <= '0;
                  sel_found_q  <= 1'b0;
                  sel_cons_q   <= 1'b0;
                  state_q      <= ST_SELECT;
                end
              end
              OP_BID: begin
                if (last_i) begin
                  sender_q     <= sender_i;
                  sweep_q      <= '0;
                  file_start_q <= fs;
                  file_main_q  <= fmain;
                  main_bank_q  <= fc_eq ? cur_bank_q : nxt_bank_q;
                  if (fs) mark_start_q[sender_i] <= 1'b1;
                  if (fmain && fc_eq) mark_cur_q[sender_i] <= 1'b1;
                  if (fmain && fn_eq) mark_nxt_q[sender_i] <= 1'b1;
                  if (fs || fmain) begin
                    state_q <= ST_FILE;
                  end else if (open_q) begin
                    state_q <= ST_CHECK;
                  end
                end
              end
              OP_FLUSH: begin
                open_q       <= 1'b0;
                bid_iter_q   <= '0;
                for (int j = 0; j < SLOTS; j++) tbl_q[j] <= {{PRICE_W{1'b0}}, NONE_WHO};
                mark_cur_q   <= '0;
                mark_nxt_q   <= '0;
                mark_start_q <= '0;
              end
              OP_FORM: begin
                open_q     <= 1'b0;
                bid_iter_q <= '0;
                for (int j = 0; j < SLOTS; j++) begin
                  tbl_q[j]  <= {{PRICE_W{1'b0}}, NONE_WHO};
                  perm_q[j] <= 3'(j);
                end
                mark_cur_q <= '0;
                mark_nxt_q <= '0;
                fnew_q     <= 1'b1;
              end
              default: ;
            endcase
          end
        end

        // one staged entry per cycle into the bank ram, start bank first
        ST_FILE: begin
          sweep_q <= sweep_q + 3'd1;
          if (sweep_q == 3'(SLOTS - 1)) begin
            if (file_start_q && file_main_q) begin
              file_start_q <= 1'b0;
            end else begin
              file_start_q <= 1'b0;
              file_main_q  <= 1'b0;
              state_q      <= open_q ? ST_CHECK : ST_IDLE;
            end
          end
        end

        ST_CHECK: begin
          if (complete) begin
            j_q      <= '0;
            v_q      <= '0;
            have_q   <= 1'b0;
            outbid_q <= 1'b0;
            state_q  <= ST_CONS_RD;
          end else begin
            state_q <= ST_IDLE;
          end
        end

        ST_CONS_RD: state_q <= ST_CONS_CMP;

        ST_CONS_CMP: begin
          best_q <= best_nx;
          v_q    <= v_q + 3'd1;
          if (v_q == 3'(SLOTS - 1)) begin
            tbl_q[j_q] <= best_nx;
            outbid_q   <= outbid_nx;
            have_q     <= 1'b0;
            if (j_q == last_lane) begin
              j_q <= '0;
              if (outbid_nx) begin
                sel_best_q  <= '0;
                sel_found_q <= 1'b0;
                sel_cons_q  <= 1'b1;
                state_q     <= ST_SELECT;
              end else begin
                state_q <= ST_ADVANCE;
              end
            end else begin
              j_q     <= j_q + 3'd1;
              state_q <= ST_CONS_RD;
            end
          end else begin
            have_q  <= have_q || cand_take;
            state_q <= ST_CONS_RD;
          end
        end

        ST_SELECT: begin
          if (sel_take) begin
            sel_best_q  <= sel_p;
            sel_task_q  <= j_q;
            sel_found_q <= 1'b1;
          end
          if (j_q == last_lane) begin
            if (sel_take) begin
              tbl_q[j_q] <= {sel_p, me_who};
            end else if (sel_found_q) begin
              tbl_q[sel_task_q] <= {sel_best_q, me_who};
            end
            j_q <= '0;
            if (sel_cons_q) begin
              state_q <= ST_ADVANCE;
            end else begin
              emit_kind_q   <= KIND_BID;
              emit_round_q  <= '0;
              clear_after_q <= 1'b0;
              state_q       <= ST_EMIT;
            end
          end else begin
            j_q <= j_q + 3'd1;
          end
        end

        ST_ADVANCE: begin
          bid_iter_q <= iter_nx[4:0];
          cur_bank_q <= nxt_bank_q;
          nxt_bank_q <= cur_bank_q;
          mark_cur_q <= mark_nxt_q;
          mark_nxt_q <= '0;
          if (iter_nx == 6'd1) mark_start_q <= '0;
          if (iter_nx >= {1'b0, iter_limit_q}) begin
            state_q <= ST_FINISH;
          end else begin
            emit_kind_q   <= KIND_BID;
            emit_round_q  <= iter_nx[4:0];
            clear_after_q <= 1'b0;
            j_q           <= '0;
            state_q       <= ST_EMIT;
          end
        end

        ST_FINISH: begin
          j_q <= '0;
          if (valid_perm) begin
            fnew_q <= 1'b0;
            if (fnew_q || !same_perm) begin
              for (int j = 0; j < SLOTS; j++) begin
                perm_q[j] <= (4'(j) < n_lanes) ? tbl_q[j].who[2:0] : 3'(j);
              end
              emit_kind_q   <= KIND_ASSIGN;
              emit_round_q  <= bid_iter_q;
              clear_after_q <= 1'b1;
              state_q       <= ST_EMIT;
            end else begin
              open_q     <= 1'b0;
              bid_iter_q <= '0;
              for (int j = 0; j < SLOTS; j++) tbl_q[j] <= {{PRICE_W{1'b0}}, NONE_WHO};
              mark_cur_q <= '0;
              mark_nxt_q <= '0;
              state_q    <= ST_IDLE;
            end
          end else begin
            out_kind_q    <= KIND_INVALID;
            out_auction_q <= auction_q;
            out_round_q   <= bid_iter_q;
            out_task_q    <= '0;
            out_price_q   <= '0;
            out_who_q     <= NONE_WHO;
            out_final_q   <= 1'b1;
            open_q        <= 1'b0;
            bid_iter_q    <= '0;
            for (int j = 0; j < SLOTS; j++) tbl_q[j] <= {{PRICE_W{1'b0}}, NONE_WHO};
            mark_cur_q    <= '0;
            mark_nxt_q    <= '0;
            state_q       <= ST_IDLE;
          end
        end

        ST_EMIT: begin
          out_kind_q    <= emit_kind_q;
          out_auction_q <= auction_q;
          out_round_q   <= emit_round_q;
          out_task_q    <= j_q;
          out_price_q   <= tbl_q[j_q].price;
          out_who_q     <= tbl_q[j_q].who;
          out_final_q   <= (j_q == last_lane);
          if (j_q == last_lane) begin
            j_q     <= '0;
            state_q <= ST_IDLE;
            if (clear_after_q) begin
              open_q     <= 1'b0;
              bid_iter_q <= '0;
              for (int j = 0; j < SLOTS; j++) tbl_q[j] <= {{PRICE_W{1'b0}}, NONE_WHO};
              mark_cur_q <= '0;
              mark_nxt_q <= '0;
            end
          end else begin
            j_q <= j_q + 3'd1;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o   = out_valid_q;
  assign kind_o           = out_kind_q;
  assign auction_number_o = out_auction_q;
  assign bid_round_o      = out_round_q;
  assign task_index_o     = out_task_q;
  assign bid_price_o      = out_price_q;
  assign winner_o         = out_who_q;
  assign final_res_o      = out_final_q;

  // an invalid assignment is always a run of one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == KIND_INVALID) |-> final_res_o)
    else $error("invalid assignment result not marked final");

  // the three bank roles always name distinct ram banks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_bank_q != nxt_bank_q) && (cur_bank_q != start_bank_q) &&
    (nxt_bank_q != start_bank_q))
    else $error("bucket bank roles overlap");

  // while closed only the start bucket may hold tables
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (mark_cur_q == '0) && (mark_nxt_q == '0))
    else $error("current or next marks set while auction closed");

  // a bid result comes only from an open auction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && emit_kind_q == KIND_BID) |-> open_q)
    else $error("bid emitted while auction closed");

endmodule
